FILE: hw/rtl/assert_macros.svh
// Clocked assertion helpers; the enclosing module provides clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ESM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define ESM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: hw/rtl/esm_pkg.sv
`default_nettype none

package esm_pkg;

   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DVS_W      = 48;
   localparam int NUM_W      = 70;
   localparam int QUO_W      = 32;
   localparam int DIV_STEPS  = QUO_W;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   // 2*pi*1e6 in Q23.16
   localparam logic [38:0] TWO_PI_1E6_Q16 = 39'd411774832291;
   localparam logic [31:0] K_LO = TWO_PI_1E6_Q16[31:0];
   localparam logic [6:0]  K_HI = TWO_PI_1E6_Q16[38:32];

   localparam logic [31:0] SPEED_NEG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] SPEED_POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [31:0] COUNT_STEP_UP   = 32'd1;
   localparam logic [31:0] COUNT_STEP_DOWN = 32'hFFFF_FFFF;

   localparam logic OP_PULSE   = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   typedef enum logic [2:0] {
      CSR_COUNT_DOWN     = 3'd0,
      CSR_COUNT_MODE     = 3'd1,
      CSR_PULSES_PER_REV = 3'd2,
      CSR_INTERVAL_US    = 3'd3,
      CSR_TIMEOUT_US     = 3'd4,
      CSR_MAX_SPEED      = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_D,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_CHECK,
      ST_DIV,
      ST_RESULT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DVS_W-1:0] num_hi;
      logic [QUO_W-1:0] num_lo;
      logic [DVS_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/encoder_speed_meter_top.sv
// Sequencing: a pulse transaction goes from idle to FINISH, which registers its response.
// A speed request uses the shared 32x32 multiplier in MUL_D, MUL_LO and MUL_HI, then runs SUM
// and CHECK, the 32 divider steps and the done strobe, then RESULT and FINISH to form and
// register the response; when the answer is zero or clamped without dividing, CHECK goes
// straight to RESULT. One transaction at a time; the 32-step restoring divider dominates a request.
// Reset (synchronous, active high): registers take their defaults, counters and times clear.
`default_nettype none
`include "assert_macros.svh"

module encoder_speed_meter_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_op,
   input  wire logic        [31:0] req_timestamp_us,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed      [31:0] rsp_speed,
   output logic signed      [31:0] rsp_pulse_count,
   output logic                    rsp_speed_valid,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic        [2:0]  csr_index,
   input  wire logic        [31:0] csr_data
);
   import esm_pkg::*;

   state_type state_ff, state_in;

   logic        count_down_ff, count_down_in;
   logic        count_mode_ff, count_mode_in;
   logic [15:0] ppr_ff, ppr_in;
   logic [23:0] interval_ff, interval_in;
   logic [31:0] timeout_ff, timeout_in;
   logic [30:0] max_speed_ff, max_speed_in;

   logic [31:0] counter_ff, counter_in;
   logic [31:0] snap_ff, snap_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] prev_ff, prev_in;

   logic             op_ff, op_in;
   logic             neg_ff, neg_in;
   logic [31:0]      mag_ff, mag_in;
   logic             skip_ff, skip_in;
   logic             ovf_ff, ovf_in;
   logic [DVS_W-1:0] divisor_ff, divisor_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [31:0]      speed_ff, speed_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_speed_ff, rsp_speed_in;
   logic [31:0] rsp_count_ff, rsp_count_in;
   logic        rsp_sv_ff, rsp_sv_in;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   div_ctl_type       div_ctl;
   div_sts_type       div_sts;
   logic [QUO_W-1:0]  quotient;

   logic [31:0] dt;
   logic [31:0] diff;
   logic [31:0] cap;
   logic        dz;

   esm_mul_unit u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   esm_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .sts      (div_sts),
      .quotient (quotient)
   );

   // configuration writes
   always_comb begin
      count_down_in = count_down_ff;
      count_mode_in = count_mode_ff;
      ppr_in        = ppr_ff;
      interval_in   = interval_ff;
      timeout_in    = timeout_ff;
      max_speed_in  = max_speed_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COUNT_DOWN:     count_down_in = csr_data[0];
            CSR_COUNT_MODE:     count_mode_in = csr_data[0];
            CSR_PULSES_PER_REV: ppr_in        = csr_data[15:0];
            CSR_INTERVAL_US:    interval_in   = csr_data[23:0];
            CSR_TIMEOUT_US:     timeout_in    = csr_data;
            CSR_MAX_SPEED:      max_speed_in  = csr_data[30:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      snap_in      = snap_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      skip_in      = skip_ff;
      ovf_in       = ovf_ff;
      divisor_in   = divisor_ff;
      num_in       = num_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sv_in    = rsp_sv_ff;
      mul_a        = '0;
      mul_b        = '0;
      dt           = last_ff - prev_ff;
      diff         = counter_ff - snap_ff;
      cap          = '0;
      dz           = (divisor_ff == '0);
      div_ctl.start   = 1'b0;
      div_ctl.num_hi  = DVS_W'(num_ff[NUM_W-1:QUO_W]);
      div_ctl.num_lo  = num_ff[QUO_W-1:0];
      div_ctl.divisor = divisor_ff;
      req_ready    = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               if (req_op == OP_PULSE) begin
                  prev_in    = last_ff;
                  last_in    = req_timestamp_us;
                  counter_in = counter_ff + (count_down_ff ? COUNT_STEP_DOWN : COUNT_STEP_UP);
                  speed_in   = '0;
                  state_in   = ST_FINISH;
               end else begin
                  if (count_mode_ff) begin
                     neg_in  = diff[31];
                     mag_in  = diff[31] ? (32'd0 - diff) : diff;
                     skip_in = 1'b0;
                     snap_in = counter_ff;
                  end else begin
                     neg_in  = 1'b0;
                     mag_in  = 32'd1;
                     skip_in = (dt == '0) || (dt > timeout_ff);
                  end
                  state_in = ST_MUL_D;
               end
            end
         end
         ST_MUL_D: begin
            mul_a    = MUL_W'(ppr_ff);
            mul_b    = count_mode_ff ? MUL_W'(interval_ff) : dt;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mul_a      = K_LO;
            mul_b      = mag_ff;
            divisor_in = prod[DVS_W-1:0];
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mul_a    = MUL_W'(K_HI);
            mul_b    = mag_ff;
            num_in   = NUM_W'(prod);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            num_in   = num_ff + {prod[NUM_W-QUO_W-1:0], {QUO_W{1'b0}}};
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // quotient of 2^32 or more is past every clamp
            ovf_in  = (DVS_W'(num_ff[NUM_W-1:QUO_W]) >= divisor_ff);
            skip_in = skip_ff || dz;
            if (skip_ff || dz || ovf_in) begin
               state_in = ST_RESULT;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (count_mode_ff) begin
               if (ovf_ff || (quotient > SPEED_NEG_LIMIT)) begin
                  cap = SPEED_NEG_LIMIT;
               end else begin
                  cap = quotient;
               end
               priority if (skip_ff) begin
                  speed_in = '0;
               end else if (neg_ff) begin
                  speed_in = 32'd0 - cap;
               end else if (cap[31]) begin
                  speed_in = SPEED_POS_LIMIT;
               end else begin
                  speed_in = cap;
               end
            end else begin
               priority if (skip_ff) begin
                  speed_in = '0;
               end else if (ovf_ff || (quotient > {1'b0, max_speed_ff})) begin
                  speed_in = {1'b0, max_speed_ff};
               end else begin
                  speed_in = quotient;
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = speed_ff;
               rsp_count_in = counter_ff;
               rsp_sv_in    = op_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_down_ff <= 1'b0;
         count_mode_ff <= 1'b0;
         ppr_ff        <= 16'd20;
         interval_ff   <= 24'd10000;
         timeout_ff    <= 32'd100000;
         max_speed_ff  <= 31'd6553600;
         counter_ff    <= '0;
         snap_ff       <= '0;
         last_ff       <= '0;
         prev_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_down_ff <= count_down_in;
         count_mode_ff <= count_mode_in;
         ppr_ff        <= ppr_in;
         interval_ff   <= interval_in;
         timeout_ff    <= timeout_in;
         max_speed_ff  <= max_speed_in;
         counter_ff    <= counter_in;
         snap_ff       <= snap_in;
         last_ff       <= last_in;
         prev_ff       <= prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      skip_ff      <= skip_in;
      ovf_ff       <= ovf_in;
      divisor_ff   <= divisor_in;
      num_ff       <= num_in;
      speed_ff     <= speed_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sv_ff    <= rsp_sv_in;
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed       = rsp_speed_ff;
   assign rsp_pulse_count = rsp_count_ff;
   assign rsp_speed_valid = rsp_sv_ff;

   `ESM_ASSERT_NXT(a_pulse_step, req_valid && req_ready && (req_op == OP_PULSE),
      counter_ff == $past(counter_ff) + ($past(count_down_ff) ? COUNT_STEP_DOWN : COUNT_STEP_UP))
   `ESM_ASSERT_IMP(a_pulse_zero_speed, rsp_valid && !rsp_speed_valid, rsp_speed == 32'sd0)
   `ESM_ASSERT_IMP(a_div_busy_state, div_sts.busy, state_ff == ST_DIV)

endmodule

`default_nettype wire

FILE: hw/rtl/esm_mul_unit.sv
`default_nettype none

module esm_mul_unit (
   input  wire logic                       clock,
   input  wire logic [esm_pkg::MUL_W-1:0]  mul_a,
   input  wire logic [esm_pkg::MUL_W-1:0]  mul_b,
   output logic      [esm_pkg::PROD_W-1:0] prod
);
   import esm_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/esm_div_unit.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees num_hi < divisor,
// so the quotient fits in QUO_W bits.
module esm_div_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire esm_pkg::div_ctl_type      ctl,
   output esm_pkg::div_sts_type           sts,
   output logic      [esm_pkg::QUO_W-1:0] quotient
);
   import esm_pkg::*;

   logic [DVS_W-1:0]      rem_ff, rem_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DVS_W:0]        trial;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[QUO_W-1]} - {1'b0, dvs_ff};
      if (ctl.start) begin
         rem_in  = ctl.num_hi;
         quo_in  = ctl.num_lo;
         dvs_in  = ctl.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so its top bit is clear
         if (!trial[DVS_W]) begin
            rem_in = trial[DVS_W-1:0];
         end else begin
            rem_in = {rem_ff[DVS_W-2:0], quo_ff[QUO_W-1]};
         end
         quo_in = {quo_ff[QUO_W-2:0], ~trial[DVS_W]};
         cnt_in = cnt_ff + STEP_CNT_W'(1);
         if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
